[rtl/assert_macros.svh]
// Assertion helpers, included by the top-level converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while in reset.
`define Y2R_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that a condition never holds, off while in reset.
`define Y2R_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

[rtl/y2r_pkg.sv]
`default_nettype none

package y2r_pkg;

   // Fixed-point format of the chroma terms
   localparam int Y2R_FRAC_BITS = 16;
   localparam int Y2R_PROD_W    = 25;
   localparam int Y2R_SUM_W     = 27;

   // Unsigned Q16 coefficients, rounded to nearest
   localparam logic [16:0] Y2R_COEF_R_V = 17'd89831;
   localparam logic [16:0] Y2R_COEF_G_V = 17'd45744;
   localparam logic [16:0] Y2R_COEF_G_U = 17'd22127;
   localparam logic [16:0] Y2R_COEF_B_U = 17'd113538;

   localparam logic signed [8:0] Y2R_CHROMA_MID = 9'sd128;
   localparam logic [7:0]        Y2R_CHAN_MAX   = 8'd255;
   localparam logic [7:0]        Y2R_SCALE_NUM  = 8'd220;

   // Default depth of the queue between front and back
   localparam int Y2R_QUEUE_DEPTH = 4;

   // One macropixel with its chroma terms worked out
   typedef struct packed {
      logic [7:0]                   luma_first;
      logic [7:0]                   luma_second;
      logic signed [Y2R_PROD_W-1:0] red_v;
      logic signed [Y2R_PROD_W-1:0] green_v;
      logic signed [Y2R_PROD_W-1:0] green_u;
      logic signed [Y2R_PROD_W-1:0] blue_u;
      logic                         frame_end;
   } y2r_chroma_type;

   // Status of the queue as seen by the front and the back
   typedef struct packed {
      logic full;
      logic empty;
   } y2r_queue_status_type;

endpackage

`default_nettype wire

[rtl/y2r_front.sv]
`default_nettype none

module y2r_front
   import y2r_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_push,
   output logic                req_full,
   input  wire logic [7:0]     req_luma_first,
   input  wire logic [7:0]     req_chroma_blue,
   input  wire logic [7:0]     req_luma_second,
   input  wire logic [7:0]     req_chroma_red,
   input  wire logic           req_frame_end,
   input  wire y2r_queue_status_type q_status,
   output logic                q_push,
   output y2r_chroma_type      q_data
);

   logic           valid_ff, valid_in;
   y2r_chroma_type data_ff, data_in;
   logic           take;

   logic signed [8:0]            du, dv;
   logic signed [Y2R_PROD_W-1:0] prod_rv, prod_gv, prod_gu, prod_bu;

   // Center the chroma and form the four chroma products
   assign du = $signed({1'b0, req_chroma_blue}) - Y2R_CHROMA_MID;
   assign dv = $signed({1'b0, req_chroma_red}) - Y2R_CHROMA_MID;

   assign prod_rv = Y2R_PROD_W'(dv) * Y2R_PROD_W'($signed({1'b0, Y2R_COEF_R_V}));
   assign prod_gv = Y2R_PROD_W'(dv) * Y2R_PROD_W'($signed({1'b0, Y2R_COEF_G_V}));
   assign prod_gu = Y2R_PROD_W'(du) * Y2R_PROD_W'($signed({1'b0, Y2R_COEF_G_U}));
   assign prod_bu = Y2R_PROD_W'(du) * Y2R_PROD_W'($signed({1'b0, Y2R_COEF_B_U}));

   // Stall only while a word is held and the queue cannot take it
   assign req_full = valid_ff && q_status.full;
   assign take     = req_push && !req_full;

   always_comb begin
      data_in.luma_first  = req_luma_first;
      data_in.luma_second = req_luma_second;
      data_in.red_v       = prod_rv;
      data_in.green_v     = prod_gv;
      data_in.green_u     = prod_gu;
      data_in.blue_u      = prod_bu;
      data_in.frame_end   = req_frame_end;
   end

   assign valid_in = take || (valid_ff && q_status.full);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Load a new word only when one is accepted
   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= data_in;
      end
   end

   assign q_push = valid_ff;
   assign q_data = data_ff;

endmodule

`default_nettype wire

[rtl/y2r_queue.sv]
`default_nettype none

module y2r_queue
   import y2r_pkg::*;
#(
   parameter int DEPTH = Y2R_QUEUE_DEPTH
)
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push,
   input  wire y2r_chroma_type  push_data,
   input  wire logic            pop,
   output y2r_chroma_type       pop_data,
   output y2r_queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   y2r_chroma_type   entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   assign push_ok = push && !status.full;
   assign pop_ok  = pop && !status.empty;

   // Advance pointers with wrap at the last entry
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the incoming word
   always_ff @(posedge clock) begin
      if (push_ok) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = entries_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[rtl/y2r_back.sv]
`default_nettype none

module y2r_back
   import y2r_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire y2r_queue_status_type q_status,
   input  wire y2r_chroma_type  q_data,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  wire logic            rsp_pop,
   output logic [7:0]           rsp_red_first,
   output logic [7:0]           rsp_green_first,
   output logic [7:0]           rsp_blue_first,
   output logic [7:0]           rsp_red_second,
   output logic [7:0]           rsp_green_second,
   output logic [7:0]           rsp_blue_second,
   output logic                 rsp_frame_end_out
);

   localparam int WHOLE_LO = Y2R_FRAC_BITS;
   localparam int WHOLE_HI = Y2R_FRAC_BITS + 7;

   // Sign-extend a chroma product to the sum width
   function automatic logic signed [Y2R_SUM_W-1:0] extend(
      input logic signed [Y2R_PROD_W-1:0] p
   );
      return {{(Y2R_SUM_W - Y2R_PROD_W){p[Y2R_PROD_W-1]}}, p};
   endfunction

   // Place the luma at the integer position of the sum
   function automatic logic signed [Y2R_SUM_W-1:0] base(input logic [7:0] y);
      return {{(Y2R_SUM_W - 8 - Y2R_FRAC_BITS){1'b0}}, y, {Y2R_FRAC_BITS{1'b0}}};
   endfunction

   // Floor, then clamp to 0..255
   function automatic logic [7:0] clamp(input logic signed [Y2R_SUM_W-1:0] s);
      logic [7:0] r;
      if (s[Y2R_SUM_W-1]) begin
         r = '0;
      end else if (|s[Y2R_SUM_W-2:WHOLE_HI+1]) begin
         r = Y2R_CHAN_MAX;
      end else begin
         r = s[WHOLE_HI:WHOLE_LO];
      end
      return r;
   endfunction

   // Scale to 0..219
   function automatic logic [7:0] scale(input logic [7:0] x);
      logic [15:0] p;
      p = 16'(x) * 16'(Y2R_SCALE_NUM);
      return p[15:8];
   endfunction

   logic a_valid_ff, a_valid_in;
   logic b_valid_ff, b_valid_in;
   logic a_ready, b_ready;

   logic [7:0] a_r0_ff, a_g0_ff, a_b0_ff, a_r1_ff, a_g1_ff, a_b1_ff;
   logic       a_end_ff;
   logic [7:0] a_r0_in, a_g0_in, a_b0_in, a_r1_in, a_g1_in, a_b1_in;

   logic signed [Y2R_SUM_W-1:0] base0, base1, term_r, term_g, term_b;

   // Stage handshakes: each stage loads when it is empty or the one after it moves
   assign b_ready = !b_valid_ff || rsp_pop;
   assign a_ready = !a_valid_ff || b_ready;
   assign q_pop   = a_ready && !q_status.empty;

   assign a_valid_in = a_ready ? !q_status.empty : 1'b1;
   assign b_valid_in = b_ready ? a_valid_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
      end
   end

   // Add the chroma terms to the luma (green subtracts them), then clamp
   assign base0  = base(q_data.luma_first);
   assign base1  = base(q_data.luma_second);
   assign term_r = extend(q_data.red_v);
   assign term_g = extend(q_data.green_v) + extend(q_data.green_u);
   assign term_b = extend(q_data.blue_u);

   assign a_r0_in = clamp(base0 + term_r);
   assign a_g0_in = clamp(base0 - term_g);
   assign a_b0_in = clamp(base0 + term_b);
   assign a_r1_in = clamp(base1 + term_r);
   assign a_g1_in = clamp(base1 - term_g);
   assign a_b1_in = clamp(base1 + term_b);

   always_ff @(posedge clock) begin
      if (q_pop) begin
         a_r0_ff  <= a_r0_in;
         a_g0_ff  <= a_g0_in;
         a_b0_ff  <= a_b0_in;
         a_r1_ff  <= a_r1_in;
         a_g1_ff  <= a_g1_in;
         a_b1_ff  <= a_b1_in;
         a_end_ff <= q_data.frame_end;
      end
   end

   // Scale into the output register; hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (b_ready && a_valid_ff) begin
         rsp_red_first     <= scale(a_r0_ff);
         rsp_green_first   <= scale(a_g0_ff);
         rsp_blue_first    <= scale(a_b0_ff);
         rsp_red_second    <= scale(a_r1_ff);
         rsp_green_second  <= scale(a_g1_ff);
         rsp_blue_second   <= scale(a_b1_ff);
         rsp_frame_end_out <= a_end_ff;
      end
   end

   assign rsp_empty = !b_valid_ff;

endmodule

`default_nettype wire

[rtl/yuyv_to_rgb_converter.sv]
// YUYV 4:2:2 to RGB converter.
// Input channel: one packed macropixel per word (two lumas, shared blue and
// red chroma, frame end flag). Drive the fields with req_push high; the word
// is taken at a rising edge where req_full is low.
// Result channel: two RGB pixels per word, each channel 0..219, and a copy of
// the frame end flag. The oldest result sits on the rsp_ ports while
// rsp_empty is low; raise rsp_pop to take it.
// Throughput: one word per cycle while the receiver keeps taking results; the
// front product stage, the queue and the two back stages (sum and clamp, then
// scale) each move a word every cycle. When the receiver stalls, the output
// register holds, the back stages fill, the queue fills, and req_full rises
// once the front register has nowhere to go; QUEUE_DEPTH + 3 words can be in
// flight. Dropping rsp_pop never loses a word.
// Reset empties every stage and the queue.
`default_nettype none
`include "assert_macros.svh"

module yuyv_to_rgb_converter
   import y2r_pkg::*;
#(
   parameter int QUEUE_DEPTH = Y2R_QUEUE_DEPTH
)
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_push,
   output logic            req_full,
   input  wire logic [7:0] req_luma_first,
   input  wire logic [7:0] req_chroma_blue,
   input  wire logic [7:0] req_luma_second,
   input  wire logic [7:0] req_chroma_red,
   input  wire logic       req_frame_end,
   output logic            rsp_empty,
   input  wire logic       rsp_pop,
   output logic [7:0]      rsp_red_first,
   output logic [7:0]      rsp_green_first,
   output logic [7:0]      rsp_blue_first,
   output logic [7:0]      rsp_red_second,
   output logic [7:0]      rsp_green_second,
   output logic [7:0]      rsp_blue_second,
   output logic            rsp_frame_end_out
);

   y2r_queue_status_type q_status;
   y2r_chroma_type       q_in_data, q_out_data;
   logic                 q_push, q_pop;

   y2r_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_luma_first  (req_luma_first),
      .req_chroma_blue (req_chroma_blue),
      .req_luma_second (req_luma_second),
      .req_chroma_red  (req_chroma_red),
      .req_frame_end   (req_frame_end),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_data          (q_in_data)
   );

   y2r_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .status    (q_status)
   );

   y2r_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_status          (q_status),
      .q_data            (q_out_data),
      .q_pop             (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_red_first     (rsp_red_first),
      .rsp_green_first   (rsp_green_first),
      .rsp_blue_first    (rsp_blue_first),
      .rsp_red_second    (rsp_red_second),
      .rsp_green_second  (rsp_green_second),
      .rsp_blue_second   (rsp_blue_second),
      .rsp_frame_end_out (rsp_frame_end_out)
   );

   // Count words in flight for the checks below
   localparam int CAPACITY = QUEUE_DEPTH + 3;
   localparam int FLIGHT_W = $clog2(CAPACITY + 1);

   logic [FLIGHT_W-1:0] in_flight_ff, in_flight_in;
   logic                word_in, word_out;

   assign word_in  = req_push && !req_full;
   assign word_out = rsp_pop && !rsp_empty;

   always_comb begin
      in_flight_in = in_flight_ff;
      if (word_in && !word_out) begin
         in_flight_in = in_flight_ff + 1'b1;
      end else if (word_out && !word_in) begin
         in_flight_in = in_flight_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   `Y2R_ASSERT_NEVER(a_result_from_nothing, clock, reset, !rsp_empty && (in_flight_ff == '0), "result shown with no word in flight")
   `Y2R_ASSERT_NEVER(a_over_capacity, clock, reset, in_flight_ff > FLIGHT_W'(CAPACITY), "more words in flight than storage")
   `Y2R_ASSERT(a_full_only_when_backed_up, clock, reset, req_full |-> (q_push && q_status.full), "input stalled while the queue has room")
   `Y2R_ASSERT(a_full_means_packed, clock, reset, req_full |-> (in_flight_ff >= FLIGHT_W'(QUEUE_DEPTH + 1)), "input stalled with words missing")

endmodule

`default_nettype wire
